[hw/rtl/rrqs_pkg.sv]
package rrqs_pkg;

	// Command codes
	typedef enum logic [2:0] {
		OP_ACTIVATE = 3'd0,
		OP_CONTINUE = 3'd1,
		OP_YIELD    = 3'd2,
		OP_SUSPEND  = 3'd3,
		OP_FINISH   = 3'd4
	} opcode_t;

	// Response status codes
	typedef enum logic [2:0] {
		RC_OK            = 3'd0,
		RC_NOT_FREE      = 3'd1,
		RC_NOT_SUSPENDED = 3'd2,
		RC_SUSPEND_EMPTY = 3'd3,
		RC_FINISH_EMPTY  = 3'd4
	} status_code_t;

	// Per-slot scheduling state
	typedef enum logic [2:0] {
		SLOT_FREE      = 3'd0,
		SLOT_READY     = 3'd1,
		SLOT_RUNNING   = 3'd2,
		SLOT_SUSPENDED = 3'd3,
		SLOT_DEAD      = 3'd4
	} slot_state_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_EXEC   = 2'd1,
		S_SWITCH = 2'd2
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture command, start table and queue reads
		logic exec;      // apply command, load response register
		logic run_next;  // mark the new running slot in the status table
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic switch_pending;  // command pops the queue head
	} sts_t;

endpackage

[hw/rtl/rrqs_ctrl.sv]
module rrqs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rrqs_pkg::cmd_t ctl,
	input  rrqs_pkg::sts_t sts
);

	rrqs_pkg::state_t state_q;
	rrqs_pkg::state_t state_nxt;
	logic             rsp_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrqs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd_ready    = 1'b0;
		ctl.load     = 1'b0;
		ctl.exec     = 1'b0;
		ctl.run_next = 1'b0;
		case (state_q)
			rrqs_pkg::S_IDLE: begin
				cmd_ready = !rsp_valid_q || rsp_ready;
				if (cmd_valid && cmd_ready) begin
					ctl.load  = 1'b1;
					state_nxt = rrqs_pkg::S_EXEC;
				end
			end
			rrqs_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.switch_pending) begin
					state_nxt = rrqs_pkg::S_SWITCH;
				end else begin
					state_nxt = rrqs_pkg::S_IDLE;
				end
			end
			rrqs_pkg::S_SWITCH: begin
				ctl.run_next = 1'b1;
				state_nxt    = rrqs_pkg::S_IDLE;
			end
			default: begin
				state_nxt = rrqs_pkg::S_IDLE;
			end
		endcase
	end

	// Hold the response until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[hw/rtl/rrqs_datapath.sv]
module rrqs_datapath #(
	parameter int NUM_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rrqs_pkg::cmd_t ctl,
	output rrqs_pkg::sts_t sts,
	input  logic [2:0]     opcode,
	input  logic [3:0]     proc_id,
	output logic [2:0]     status_code,
	output logic [3:0]     running_id,
	output logic [3:0]     previous_id,
	output logic           switched,
	output logic [3:0]     ready_count,
	output logic           queue_empty
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int IW = (SW > 4) ? SW : 4;
	localparam int KW = (CW > 4) ? CW : 4;

	// Status table, fill marks and ready queue
	rrqs_pkg::slot_state_t status_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  written_q;
	logic [SW-1:0]         fifo_mem [NUM_SLOTS];

	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] cur_q;

	// Captured command and registered reads
	logic [2:0]            op_q;
	logic [SW-1:0]         idx_q;
	logic                  ok_q;
	rrqs_pkg::slot_state_t rd_state_q;
	logic                  rd_written_q;
	logic [SW-1:0]         head_rd_q;

	logic [IW-1:0]         in_ext;
	logic [SW-1:0]         in_idx;
	logic                  in_ok;
	rrqs_pkg::slot_state_t st_eff;

	rrqs_pkg::status_code_t code;
	logic                   push;
	logic                   push_ok;
	logic                   pop;
	logic [SW-1:0]          push_val;
	logic                   wr_en;
	logic [SW-1:0]          wr_addr;
	rrqs_pkg::slot_state_t  wr_val;
	logic [SW-1:0]          next_cur;
	logic [CW-1:0]          count_nxt;
	logic                   nonempty;

	logic                   mem_we;
	logic [SW-1:0]          mem_addr;
	rrqs_pkg::slot_state_t  mem_data;

	logic [IW-1:0]          run_ext;
	logic [IW-1:0]          prev_ext;
	logic [KW-1:0]          cnt_ext;

	function automatic logic [SW-1:0] ptr_next(input logic [SW-1:0] ptr);
		ptr_next = (int'(ptr) == NUM_SLOTS - 1) ? '0 : ptr + SW'(1);
	endfunction

	// Map the incoming slot number onto the table
	assign in_ext = IW'(proc_id);
	assign in_idx = in_ext[SW-1:0];
	assign in_ok  = int'(proc_id) < NUM_SLOTS;

	// Capture the command
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= opcode;
			idx_q <= in_idx;
			ok_q  <= in_ok;
		end
	end

	// Unwritten entries read as their reset state
	assign st_eff = rd_written_q ? rd_state_q :
		((idx_q == '0) ? rrqs_pkg::SLOT_RUNNING : rrqs_pkg::SLOT_FREE);

	assign nonempty = count_q != '0;

	// Decide the command's effect
	always_comb begin
		code     = rrqs_pkg::RC_OK;
		push     = 1'b0;
		pop      = 1'b0;
		push_val = cur_q;
		wr_en    = 1'b0;
		wr_addr  = cur_q;
		wr_val   = rrqs_pkg::SLOT_READY;
		next_cur = cur_q;
		case (rrqs_pkg::opcode_t'(op_q))
			rrqs_pkg::OP_ACTIVATE: begin
				if (ok_q && st_eff == rrqs_pkg::SLOT_FREE) begin
					wr_en    = 1'b1;
					wr_addr  = idx_q;
					push     = 1'b1;
					push_val = idx_q;
				end else begin
					code = rrqs_pkg::RC_NOT_FREE;
				end
			end
			rrqs_pkg::OP_CONTINUE: begin
				if (ok_q && st_eff == rrqs_pkg::SLOT_SUSPENDED) begin
					wr_en    = 1'b1;
					wr_addr  = idx_q;
					push     = 1'b1;
					push_val = idx_q;
				end else begin
					code = rrqs_pkg::RC_NOT_SUSPENDED;
				end
			end
			rrqs_pkg::OP_YIELD: begin
				if (nonempty) begin
					push     = 1'b1;
					pop      = 1'b1;
					wr_en    = 1'b1;
					next_cur = head_rd_q;
				end
			end
			rrqs_pkg::OP_SUSPEND: begin
				if (nonempty) begin
					pop      = 1'b1;
					wr_en    = 1'b1;
					wr_val   = rrqs_pkg::SLOT_SUSPENDED;
					next_cur = head_rd_q;
				end else begin
					code = rrqs_pkg::RC_SUSPEND_EMPTY;
				end
			end
			rrqs_pkg::OP_FINISH: begin
				if (nonempty) begin
					pop      = 1'b1;
					wr_en    = 1'b1;
					wr_val   = rrqs_pkg::SLOT_DEAD;
					next_cur = head_rd_q;
				end else begin
					code = rrqs_pkg::RC_FINISH_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Drop a push onto a full queue
	assign push_ok   = push && (count_q != CW'(NUM_SLOTS));
	assign count_nxt = count_q + CW'(push_ok) - CW'(pop);

	assign sts.switch_pending = pop;

	// Status table port: retire in exec, mark new running slot after
	assign mem_we   = (ctl.exec && wr_en) || ctl.run_next;
	assign mem_addr = ctl.run_next ? cur_q : wr_addr;
	assign mem_data = ctl.run_next ? rrqs_pkg::SLOT_RUNNING : wr_val;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			status_mem[mem_addr] <= mem_data;
		end
		if (ctl.load) begin
			rd_state_q <= status_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (mem_we) begin
			written_q[mem_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_written_q <= written_q[in_idx];
		end
	end

	// Ready queue storage
	always_ff @(posedge clk) begin
		if (ctl.exec && push_ok) begin
			fifo_mem[tail_q] <= push_val;
		end
		if (ctl.load) begin
			head_rd_q <= fifo_mem[head_q];
		end
	end

	// Advance queue pointers and the running slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cur_q   <= '0;
		end else if (ctl.exec) begin
			if (push_ok) begin
				tail_q <= ptr_next(tail_q);
			end
			if (pop) begin
				head_q <= ptr_next(head_q);
			end
			count_q <= count_nxt;
			cur_q   <= next_cur;
		end
	end

	// Response register
	assign run_ext  = IW'(next_cur);
	assign prev_ext = IW'(cur_q);
	assign cnt_ext  = KW'(count_nxt);

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_code <= code;
			running_id  <= run_ext[3:0];
			previous_id <= prev_ext[3:0];
			switched    <= next_cur != cur_q;
			ready_count <= cnt_ext[3:0];
			queue_empty <= count_nxt == '0;
		end
	end

endmodule

[hw/rtl/round_robin_ready_queue_scheduler.sv]
// Round-robin thread scheduler: one command (activate, continue, yield,
// suspend, finish) goes in per transaction and exactly one response comes
// out. The response register is loaded in the execute state, which follows
// acceptance; a command also visits the switch state when it switches the
// running slot, because the status table has a registered read port and a
// single write port: the old slot is retired in one cycle and the new head is
// marked running in the next. The next command is accepted once the
// controller is back in idle and the response register is empty or being
// drained in that cycle. Slot 0 runs after reset, every other slot is free;
// the status table needs no clearing pass, since slots never written read as
// their reset state.
module round_robin_ready_queue_scheduler #(
	parameter int NUM_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  logic [2:0] opcode,
	input  logic [3:0] proc_id,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [2:0] status_code,
	output logic [3:0] running_id,
	output logic [3:0] previous_id,
	output logic       switched,
	output logic [3:0] ready_count,
	output logic       queue_empty
);

	rrqs_pkg::cmd_t ctl;
	rrqs_pkg::sts_t sts;

	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	rrqs_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.opcode      (opcode),
		.proc_id     (proc_id),
		.status_code (status_code),
		.running_id  (running_id),
		.previous_id (previous_id),
		.switched    (switched),
		.ready_count (ready_count),
		.queue_empty (queue_empty)
	);

endmodule

[hw/rtl/rrqs_checker.sv]
module rrqs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status_code,
	input logic [3:0] running_id,
	input logic [3:0] previous_id,
	input logic       switched
);

	// One command in flight: no back-to-back acceptance
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while previous one in flight");

	// Switch flag agrees with the reported slots
	a_switch_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (switched == (running_id != previous_id)))
		else $error("switched flag inconsistent with slot ids");

	// A rejected command never changes the running slot
	a_err_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status_code != rrqs_pkg::RC_OK |-> !switched)
		else $error("error response with a slot switch");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status_code)
			&& $stable(running_id) && $stable(previous_id))
		else $error("stalled response changed");

endmodule

bind round_robin_ready_queue_scheduler rrqs_checker u_rrqs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_ready   (cmd_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.status_code (status_code),
	.running_id  (running_id),
	.previous_id (previous_id),
	.switched    (switched)
);

[tb/sv/round_robin_ready_queue_scheduler_checker.sv]
`timescale 1ns / 1ps

module round_robin_ready_queue_scheduler_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_ready,
	input  logic [2:0] opcode,
	input  logic [3:0] proc_id,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  logic [2:0] status_code,
	input  logic [3:0] running_id,
	input  logic [3:0] previous_id,
	input  logic       switched,
	input  logic [3:0] ready_count,
	input  logic       queue_empty,
	output int         fail_count,
	output int         pending,
	output int         checked
);

	localparam int NUM_SLOTS = 16;

	typedef struct packed {
		rrqs_pkg::status_code_t code;
		logic [3:0]             running;
		logic [3:0]             previous;
		logic                   switched;
		logic [3:0]             count;
		logic                   empty;
	} sched_rsp_t;

	// Shadow scheduler state
	rrqs_pkg::slot_state_t slot_tbl [NUM_SLOTS];
	logic [3:0]            rq_mem [NUM_SLOTS];
	logic [3:0]            rq_head;
	logic [3:0]            rq_tail;
	logic [4:0]            rq_count;
	logic [3:0]            run_slot;

	sched_rsp_t  rsp_q [$];
	sched_rsp_t  want;

	// Push a slot at the tail; a full queue drops it (4-bit pointers wrap at 16)
	function automatic void enqueue_slot(logic [3:0] slot);
		if (rq_count < NUM_SLOTS) begin
			rq_mem[rq_tail] = slot;
			rq_tail = rq_tail + 4'd1;
			rq_count = rq_count + 5'd1;
		end
	endfunction

	// Retire the running slot and run the queue head
	function automatic void dispatch_head(rrqs_pkg::slot_state_t retired);
		logic [3:0] nxt;
		nxt = rq_mem[rq_head];
		rq_head = rq_head + 4'd1;
		rq_count = rq_count - 5'd1;
		slot_tbl[run_slot] = retired;
		slot_tbl[nxt] = rrqs_pkg::SLOT_RUNNING;
		run_slot = nxt;
	endfunction

	// Apply one command to the shadow state and build its response
	function automatic sched_rsp_t schedule_cmd(logic [2:0] op, logic [3:0] id);
		sched_rsp_t r;
		logic [3:0] prev;
		prev = run_slot;
		r.code = rrqs_pkg::RC_OK;
		case (op)
			rrqs_pkg::OP_ACTIVATE: begin
				if (slot_tbl[id] == rrqs_pkg::SLOT_FREE) begin
					slot_tbl[id] = rrqs_pkg::SLOT_READY;
					enqueue_slot(id);
				end else begin
					r.code = rrqs_pkg::RC_NOT_FREE;
				end
			end
			rrqs_pkg::OP_CONTINUE: begin
				if (slot_tbl[id] == rrqs_pkg::SLOT_SUSPENDED) begin
					slot_tbl[id] = rrqs_pkg::SLOT_READY;
					enqueue_slot(id);
				end else begin
					r.code = rrqs_pkg::RC_NOT_SUSPENDED;
				end
			end
			rrqs_pkg::OP_YIELD: begin
				if (rq_count != 0) begin
					enqueue_slot(run_slot);
					dispatch_head(rrqs_pkg::SLOT_READY);
				end
			end
			rrqs_pkg::OP_SUSPEND: begin
				if (rq_count != 0)
					dispatch_head(rrqs_pkg::SLOT_SUSPENDED);
				else
					r.code = rrqs_pkg::RC_SUSPEND_EMPTY;
			end
			rrqs_pkg::OP_FINISH: begin
				if (rq_count != 0)
					dispatch_head(rrqs_pkg::SLOT_DEAD);
				else
					r.code = rrqs_pkg::RC_FINISH_EMPTY;
			end
			default: ;
		endcase
		r.running = run_slot;
		r.previous = prev;
		r.switched = (run_slot != prev);
		r.count = rq_count[3:0];
		r.empty = (rq_count == 0);
		return r;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic check_field(input string name, input int got, input int exp_val);
		if (got != exp_val)
			report_mismatch($sformatf("response %0d field %s got %0d expected %0d",
				checked, name, got, exp_val));
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
	end

	// Compare each response transaction, then predict each command transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_tbl[i] = rrqs_pkg::SLOT_FREE;
				rq_mem[i] = 4'd0;
			end
			slot_tbl[0] = rrqs_pkg::SLOT_RUNNING;
			rq_head = 4'd0;
			rq_tail = 4'd0;
			rq_count = 5'd0;
			run_slot = 4'd0;
			rsp_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_q.size() == 0) begin
					report_mismatch($sformatf("response with no command outstanding, status %0d",
						status_code));
				end else begin
					want = rsp_q.pop_front();
					check_field("status_code", status_code, want.code);
					check_field("running_id", running_id, want.running);
					check_field("previous_id", previous_id, want.previous);
					check_field("switched", switched, want.switched);
					check_field("ready_count", ready_count, want.count);
					check_field("queue_empty", queue_empty, want.empty);
					checked = checked + 1;
				end
			end
			if (cmd_valid && cmd_ready)
				rsp_q.push_back(schedule_cmd(opcode, proc_id));
			pending = rsp_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASE_ITEMS = 345;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST = 3'd7;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	logic [2:0] opcode = 3'd0;
	logic [3:0] proc_id = 4'd0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [2:0] status_code;
	logic [3:0] running_id;
	logic [3:0] previous_id;
	logic       switched;
	logic [3:0] ready_count;
	logic       queue_empty;

	int fail_count;
	int pending;
	int checked;
	int sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_cnt = 0;

	round_robin_ready_queue_scheduler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.opcode      (opcode),
		.proc_id     (proc_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status_code (status_code),
		.running_id  (running_id),
		.previous_id (previous_id),
		.switched    (switched),
		.ready_count (ready_count),
		.queue_empty (queue_empty)
	);

	round_robin_ready_queue_scheduler_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.opcode      (opcode),
		.proc_id     (proc_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status_code (status_code),
		.running_id  (running_id),
		.previous_id (previous_id),
		.switched    (switched),
		.ready_count (ready_count),
		.queue_empty (queue_empty),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Stall the response side at random
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("round_robin_ready_queue_scheduler regression: fail");
			$finish;
		end
	end

	// Drive one command transaction; entered and left at a falling edge
	task automatic send_cmd(input logic [2:0] op, input logic [3:0] id);
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		proc_id <= id;
		do @(posedge clk); while (!cmd_ready);
		sent = sent + 1;
		@(negedge clk);
	endtask

	// Hold off the sender until every response is back
	task automatic drain;
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// Mostly queue-feeding commands, rare finishes so slots stay alive
	task automatic send_random_cmd;
		int r;
		logic [2:0] op;
		r = $urandom_range(0, 149);
		if (r < 38)
			op = rrqs_pkg::OP_ACTIVATE;
		else if (r < 76)
			op = rrqs_pkg::OP_CONTINUE;
		else if (r < 110)
			op = rrqs_pkg::OP_YIELD;
		else if (r < 142)
			op = rrqs_pkg::OP_SUSPEND;
		else if (r < 143)
			op = rrqs_pkg::OP_FINISH;
		else
			op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
		send_cmd(op, 4'($urandom_range(0, 15)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty-queue cases straight after reset
		send_cmd(rrqs_pkg::OP_YIELD, 4'd0);
		send_cmd(rrqs_pkg::OP_SUSPEND, 4'd15);
		send_cmd(rrqs_pkg::OP_FINISH, 4'd0);
		send_cmd(rrqs_pkg::OP_CONTINUE, 4'd3);
		send_cmd(OP_RSVD_LAST, 4'd9);

		// Fill the queue with every other slot
		for (int s = 1; s < 16; s++)
			send_cmd(rrqs_pkg::OP_ACTIVATE, 4'(s));

		// Not-free, switch, suspend/continue, finish and attempted reuse of a dead slot
		send_cmd(rrqs_pkg::OP_ACTIVATE, 4'd0);
		send_cmd(rrqs_pkg::OP_ACTIVATE, 4'd15);
		send_cmd(rrqs_pkg::OP_YIELD, 4'd0);
		send_cmd(rrqs_pkg::OP_SUSPEND, 4'd0);
		send_cmd(rrqs_pkg::OP_CONTINUE, 4'd1);
		send_cmd(rrqs_pkg::OP_CONTINUE, 4'd4);
		send_cmd(rrqs_pkg::OP_FINISH, 4'd0);
		send_cmd(rrqs_pkg::OP_ACTIVATE, 4'd2);
		drain();

		// Random phases with different pacing
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 74; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 74; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_cmd();
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d commands: directed edge cases plus four pacing phases",
			sent);
		$display("%0d responses compared field by field, %0d mismatches",
			checked, fail_count);
		if (fail_count == 0)
			$display("round_robin_ready_queue_scheduler regression: pass");
		else
			$display("round_robin_ready_queue_scheduler regression: fail");
		$finish;
	end

endmodule
